/* hw/rtl/bdh_pkg.sv */
// bdh_pkg: shared types and constants for the button debounce / hold detect block
// no dependencies
`default_nettype none

package bdh_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W   = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_HOLD     = 2'd1,
		CFG_LONG     = 2'd2
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd40;
	localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;
	localparam logic [CFG_W-1:0] LONG_RESET     = 16'd3000;

	// single-bit state carried from tick to tick
	typedef struct packed {
		logic last_sample;
		logic stable_level;
		logic hold_fired;
		logic long_fired;
		logic press_flag;
		logic hold_flag;
		logic long_flag;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{
		last_sample:  1'b1,
		stable_level: 1'b1,
		hold_fired:   1'b0,
		long_fired:   1'b0,
		press_flag:   1'b0,
		hold_flag:    1'b0,
		long_flag:    1'b0
	};

	typedef struct packed {
		logic button_level;
		logic take_press;
		logic take_hold;
		logic take_long;
	} tick_t;

	typedef struct packed {
		logic press_taken;
		logic hold_taken;
		logic long_taken;
		logic debounced_level;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/button_debounce_hold_detect.sv */
// Button debounce with hold and long-press detection. One item in per tick, one
// result item out per tick; an item is taken every clock cycle while s_tready is
// high, limited only by the state update logic between the state registers and the
// output register, and its result is registered in the output register. A new
// level is accepted once the raw sample has been steady for debounce_ticks ticks;
// hold and long events fire once per press at hold_ticks and long_ticks held ticks,
// and a release without a hold raises a short press. Pending events are handed back
// when the matching take bit is set. Configuration is written through cfg_we /
// cfg_index / cfg_data while idle, a user rule the block does not enforce.
// depends on bdh_pkg and bdh_step
`default_nettype none

module button_debounce_hold_detect #(
	parameter int COUNT_BITS = 16
) (
	input  var logic                          clk,
	input  var logic                          arst_n,
	input  var logic                          s_tvalid,
	output logic                              s_tready,
	// [0] button_level, [1] take_press, [2] take_hold, [3] take_long, [7:4] zero
	input  var logic [bdh_pkg::TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  var logic                          m_tready,
	// [0] press_taken, [1] hold_taken, [2] long_taken, [3] debounced_level, [7:4] zero
	output logic [bdh_pkg::TDATA_W-1:0]       m_tdata,
	input  var logic                          cfg_we,
	input  var logic [bdh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  var logic [bdh_pkg::CFG_W-1:0]     cfg_data
);
	import bdh_pkg::*;

	logic [CFG_W-1:0]      debounce_ticks_q;
	logic [CFG_W-1:0]      hold_ticks_q;
	logic [CFG_W-1:0]      long_ticks_q;
	flags_t                flags_q;
	flags_t                flags_nxt;
	logic [COUNT_BITS-1:0] quiet_q;
	logic [COUNT_BITS-1:0] quiet_nxt;
	logic [COUNT_BITS-1:0] held_q;
	logic [COUNT_BITS-1:0] held_nxt;
	tick_t                 tick;
	result_t               result;
	result_t               result_q;
	logic                  m_tvalid_q;
	logic                  in_fire;

	assign tick.button_level = s_tdata[0];
	assign tick.take_press   = s_tdata[1];
	assign tick.take_hold    = s_tdata[2];
	assign tick.take_long    = s_tdata[3];

	// output register frees up in the same cycle it is taken
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	bdh_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.tick          (tick),
		.flags         (flags_q),
		.quiet_cnt     (quiet_q),
		.held_cnt      (held_q),
		.debounce_ticks(debounce_ticks_q),
		.hold_ticks    (hold_ticks_q),
		.long_ticks    (long_ticks_q),
		.flags_nxt     (flags_nxt),
		.quiet_nxt     (quiet_nxt),
		.held_nxt      (held_nxt),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
			hold_ticks_q     <= HOLD_RESET;
			long_ticks_q     <= LONG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_ticks_q <= cfg_data;
				CFG_HOLD:     hold_ticks_q     <= cfg_data;
				CFG_LONG:     long_ticks_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= FLAGS_RESET;
			quiet_q    <= '0;
			held_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				flags_q <= flags_nxt;
				quiet_q <= quiet_nxt;
				held_q  <= held_nxt;
			end
			if (in_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, result_q.debounced_level, result_q.long_taken,
		result_q.hold_taken, result_q.press_taken};

endmodule

`default_nettype wire

/* hw/rtl/bdh_step.sv */
// bdh_step: next-state and result logic for one tick
// depends on bdh_pkg
`default_nettype none

module bdh_step #(
	parameter int COUNT_BITS = 16
) (
	input  var bdh_pkg::tick_t            tick,
	input  var bdh_pkg::flags_t           flags,
	input  var logic [COUNT_BITS-1:0]     quiet_cnt,
	input  var logic [COUNT_BITS-1:0]     held_cnt,
	input  var logic [bdh_pkg::CFG_W-1:0] debounce_ticks,
	input  var logic [bdh_pkg::CFG_W-1:0] hold_ticks,
	input  var logic [bdh_pkg::CFG_W-1:0] long_ticks,
	output bdh_pkg::flags_t               flags_nxt,
	output logic [COUNT_BITS-1:0]         quiet_nxt,
	output logic [COUNT_BITS-1:0]         held_nxt,
	output bdh_pkg::result_t              result
);
	import bdh_pkg::*;

	localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic accept;
	logic just_pressed;

	always_comb begin
		flags_nxt    = flags;
		held_nxt     = held_cnt;
		just_pressed = 1'b0;

		// takes act on the flags as they stood before this tick
		result.press_taken = tick.take_press & flags.press_flag;
		result.hold_taken  = tick.take_hold & flags.hold_flag;
		result.long_taken  = tick.take_long & flags.long_flag;
		if (result.press_taken) flags_nxt.press_flag = 1'b0;
		if (result.hold_taken)  flags_nxt.hold_flag  = 1'b0;
		if (result.long_taken)  flags_nxt.long_flag  = 1'b0;

		if (tick.button_level != flags.last_sample) begin
			flags_nxt.last_sample = tick.button_level;
			quiet_nxt = '0;
		end else if (quiet_cnt == CNT_MAX) begin
			quiet_nxt = quiet_cnt;
		end else begin
			quiet_nxt = quiet_cnt + 1'b1;
		end

		accept = (CMP_W'(quiet_nxt) >= CMP_W'(debounce_ticks))
			&& (tick.button_level != flags.stable_level);

		if (accept) begin
			flags_nxt.stable_level = tick.button_level;
			if (!tick.button_level) begin
				just_pressed         = 1'b1;
				flags_nxt.hold_fired = 1'b0;
				flags_nxt.long_fired = 1'b0;
			end else if (!flags.hold_fired) begin
				flags_nxt.press_flag = 1'b1;
			end
		end

		if (!flags_nxt.stable_level) begin
			if (just_pressed) begin
				held_nxt = '0;
			end else if (held_cnt == CNT_MAX) begin
				held_nxt = held_cnt;
			end else begin
				held_nxt = held_cnt + 1'b1;
			end
			if (!flags_nxt.hold_fired && CMP_W'(held_nxt) >= CMP_W'(hold_ticks)) begin
				flags_nxt.hold_flag  = 1'b1;
				flags_nxt.hold_fired = 1'b1;
			end
			if (!flags_nxt.long_fired && CMP_W'(held_nxt) >= CMP_W'(long_ticks)) begin
				flags_nxt.long_flag  = 1'b1;
				flags_nxt.long_fired = 1'b1;
			end
		end

		result.debounced_level = flags_nxt.stable_level;
	end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for button_debounce_hold_detect: directed table and random press/bounce
// sequences, checked against table values or an in-bench debounce model
// depends on bdh_pkg and the button_debounce_hold_detect rtl
`default_nettype none

module testbench;
	import bdh_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
	localparam logic [CFG_W-1:0]     CNT_TOP  = 16'hFFFF;
	localparam int LONG_STALL = 300;
	localparam int PHASE_ITEMS = 210;

	localparam result_t QUIET_RELEASED = '{1'b0, 1'b0, 1'b0, 1'b1};
	localparam result_t QUIET_PRESSED  = '{1'b0, 1'b0, 1'b0, 1'b0};

	typedef struct {
		bit                     is_cfg;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_W-1:0]       value;
		tick_t                  t;
		bit                     typed;
		result_t                want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// model state and register copies
	flags_t     btn = FLAGS_RESET;
	logic [15:0] quiet_ticks = '0;
	logic [15:0] held_ticks = '0;
	logic [15:0] debounce_cfg = DEBOUNCE_RESET;
	logic [15:0] hold_cfg = HOLD_RESET;
	logic [15:0] long_cfg = LONG_RESET;

	result_t reports_due[$];
	int      errors = 0;
	bit      send_gaps = 1'b1;
	bit      recv_gaps = 1'b1;
	bit      long_stall_req = 1'b0;
	int      stall_left = 0;

	button_debounce_hold_detect #(.COUNT_BITS(16)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [TDATA_W-1:0] pack_tick(tick_t t);
		return {4'b0, t.take_long, t.take_hold, t.take_press, t.button_level};
	endfunction

	function automatic logic [TDATA_W-1:0] pack_report(result_t r);
		return {4'b0, r.debounced_level, r.long_taken, r.hold_taken, r.press_taken};
	endfunction

	// one tick: takes act on the flags as they stood, then debounce, then hold timing
	function automatic result_t debounce_step(tick_t t);
		result_t r;
		logic just_pressed;
		r = '0;
		just_pressed = 1'b0;
		if (t.take_press && btn.press_flag) begin
			btn.press_flag = 1'b0;
			r.press_taken = 1'b1;
		end
		if (t.take_hold && btn.hold_flag) begin
			btn.hold_flag = 1'b0;
			r.hold_taken = 1'b1;
		end
		if (t.take_long && btn.long_flag) begin
			btn.long_flag = 1'b0;
			r.long_taken = 1'b1;
		end
		if (t.button_level != btn.last_sample) begin
			btn.last_sample = t.button_level;
			quiet_ticks = '0;
		end else if (quiet_ticks != CNT_TOP) begin
			quiet_ticks = quiet_ticks + 16'd1;
		end
		if (quiet_ticks >= debounce_cfg && t.button_level != btn.stable_level) begin
			btn.stable_level = t.button_level;
			if (!btn.stable_level) begin
				just_pressed = 1'b1;
				btn.hold_fired = 1'b0;
				btn.long_fired = 1'b0;
			end else if (!btn.hold_fired) begin
				btn.press_flag = 1'b1;
			end
		end
		if (!btn.stable_level) begin
			if (just_pressed)
				held_ticks = '0;
			else if (held_ticks != CNT_TOP)
				held_ticks = held_ticks + 16'd1;
			if (!btn.hold_fired && held_ticks >= hold_cfg) begin
				btn.hold_flag = 1'b1;
				btn.hold_fired = 1'b1;
			end
			if (!btn.long_fired && held_ticks >= long_cfg) begin
				btn.long_flag = 1'b1;
				btn.long_fired = 1'b1;
			end
		end
		r.debounced_level = btn.stable_level;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75)
			return $urandom_range(1, 2);
		else if (pick < 95)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic tick_t random_tick(logic lvl);
		tick_t t;
		t.button_level = lvl;
		t.take_press = ($urandom_range(0, 3) == 0);
		t.take_hold = ($urandom_range(0, 3) == 0);
		t.take_long = ($urandom_range(0, 3) == 0);
		return t;
	endfunction

	function automatic plan_row_t tick_row(logic lvl, logic tp, logic th, logic tl);
		plan_row_t row;
		row = '{default: '0};
		row.t = '{lvl, tp, th, tl};
		return row;
	endfunction

	function automatic plan_row_t checked_row(logic lvl, logic tp, logic th, logic tl,
			result_t want);
		plan_row_t row;
		row = tick_row(lvl, tp, th, tl);
		row.typed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.value = value;
		return row;
	endfunction

	task automatic send_tick(tick_t t, bit typed, result_t want);
		int n;
		result_t predicted;
		n = 0;
		if (send_gaps && $urandom_range(0, 2) == 0)
			n = gap_len();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_tick(t);
		do @(posedge clk); while (!s_tready);
		predicted = debounce_step(t);
		reports_due.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_DEBOUNCE: debounce_cfg = value;
			CFG_HOLD:     hold_cfg = value;
			CFG_LONG:     long_cfg = value;
			default: ;
		endcase
	endtask

	task automatic check_report(logic [TDATA_W-1:0] got);
		result_t want;
		if (reports_due.size() == 0) begin
			$display("%0t: unexpected item, got press %b hold %b long %b level %b pad %h",
				$time, got[0], got[1], got[2], got[3], got[7:4]);
			errors++;
		end else begin
			want = reports_due.pop_front();
			if (got !== pack_report(want)) begin
				$display("%0t: mismatch, expected press %b hold %b long %b level %b pad 0",
					$time, want.press_taken, want.hold_taken, want.long_taken,
					want.debounced_level);
				$display("%0t:           actual press %b hold %b long %b level %b pad %h",
					$time, got[0], got[1], got[2], got[3], got[7:4]);
				errors++;
			end
		end
	endtask

	// receiver: checks each item and chooses tready for the next cycle
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				check_report(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL - 1;
				m_tready <= 1'b0;
			end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
				stall_left = gap_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		plan_row_t plan[$];
		int rnd_debounce[6];
		int rnd_hold[6];
		int rnd_long[6];
		int count;
		int len;
		int kind;
		logic lvl;

		rnd_debounce = '{0, 1, 3, 0, 2, 4};
		rnd_hold     = '{0, 3, 8, 5, 12, 20};
		rnd_long     = '{0, 6, 20, 5, 4, 40};

		// reset register values, take with nothing pending, a bounce
		plan.push_back(checked_row(1'b1, 1'b1, 1'b1, 1'b1, QUIET_RELEASED));
		plan.push_back(checked_row(1'b0, 1'b0, 1'b0, 1'b0, QUIET_RELEASED));
		// zero debounce and hold: press accepted and hold raised on the same tick
		plan.push_back(cfg_row(CFG_DEBOUNCE, 16'd0));
		plan.push_back(cfg_row(CFG_HOLD, 16'd0));
		plan.push_back(cfg_row(CFG_LONG, 16'd1));
		plan.push_back(checked_row(1'b0, 1'b0, 1'b0, 1'b0, QUIET_PRESSED));
		// long raised on the tick it is asked for stays pending
		plan.push_back(tick_row(1'b0, 1'b0, 1'b1, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b1));
		plan.push_back(tick_row(1'b1, 1'b1, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b1, 1'b1, 1'b1, 1'b1));
		// maximum thresholds: short press only
		plan.push_back(cfg_row(CFG_HOLD, CNT_TOP));
		plan.push_back(cfg_row(CFG_LONG, CNT_TOP));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b1, 1'b1, 1'b1, 1'b0));
		plan.push_back(cfg_row(CFG_DEBOUNCE, CNT_TOP));
		plan.push_back(checked_row(1'b0, 1'b1, 1'b0, 1'b0, QUIET_RELEASED));
		// write to an unused index leaves the debounce count alone
		plan.push_back(cfg_row(CFG_NONE, 16'd0));
		plan.push_back(checked_row(1'b0, 1'b0, 1'b0, 1'b0, QUIET_RELEASED));
		plan.push_back(cfg_row(CFG_DEBOUNCE, 16'd2));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b1, 1'b1, 1'b1, 1'b1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_results();
				write_cfg(plan[i].idx, plan[i].value);
			end else begin
				send_tick(plan[i].t, plan[i].typed, plan[i].want);
			end
		end

		// random press, release and bounce runs under several threshold settings
		lvl = 1'b1;
		for (int p = 0; p < 6; p++) begin
			drain_results();
			write_cfg(CFG_DEBOUNCE, rnd_debounce[p][15:0]);
			write_cfg(CFG_HOLD, rnd_hold[p][15:0]);
			write_cfg(CFG_LONG, rnd_long[p][15:0]);
			count = 0;
			while (count < PHASE_ITEMS) begin
				send_gaps = ($urandom_range(0, 3) != 0);
				recv_gaps = ($urandom_range(0, 3) != 0);
				if (p == 2 && count == 0) begin
					// sink holds off while items keep coming
					send_gaps = 1'b0;
					long_stall_req = 1'b1;
				end
				if (p == 3 && count >= PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 8)
					drain_results();
				kind = $urandom_range(0, 9);
				lvl = ~lvl;
				if (kind == 9) begin
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++)
						send_tick(random_tick(1'($urandom_range(0, 1))), 1'b0, '0);
				end else begin
					if (kind < 2)
						len = $urandom_range(1, rnd_debounce[p] > 0 ? rnd_debounce[p] : 1);
					else if (kind < 6)
						len = $urandom_range(rnd_debounce[p] + 1,
							rnd_debounce[p] + rnd_hold[p] + 2);
					else
						len = $urandom_range(rnd_debounce[p] + rnd_long[p] + 1,
							rnd_debounce[p] + rnd_long[p] + 10);
					for (int k = 0; k < len; k++)
						send_tick(random_tick(lvl), 1'b0, '0);
				end
				count += len;
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/bdh_pkg.sv
hw/rtl/bdh_step.sv
hw/rtl/button_debounce_hold_detect.sv
tb/testbench.sv
